### hw/rtl/jbe_pkg.sv
`default_nettype none
package jbe_pkg;

    localparam int DC_SYMBOLS = 12;
    localparam int AC_SYMBOLS = 256;
    localparam int MAX_OUT    = 16;

    localparam int DC_DEPTH  = 2 * DC_SYMBOLS;
    localparam int DC_ADDR_W = $clog2(DC_DEPTH);
    localparam int AC_DEPTH  = 2 * AC_SYMBOLS;
    localparam int AC_ADDR_W = $clog2(AC_DEPTH);
    localparam int DC_LIM    = (1 << (DC_SYMBOLS - 1)) - 1;

    localparam logic [7:0] SYM_ZRL    = 8'hf0;
    localparam logic [7:0] SYM_EOB    = 8'h00;
    localparam logic [7:0] BYTE_FF    = 8'hff;
    localparam logic [7:0] BYTE_STUFF = 8'h00;

    localparam logic [1:0] MODE_COEF  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Stored Huffman code: right aligned value and its length.
    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] code;
    } t_code;

    // One coding job handed from the front to the packer.
    typedef struct packed {
        logic        flush;
        logic [1:0]  nzrl;
        t_code       zrl;
        t_code       sym;
        logic [11:0] mag;
        logic [3:0]  mag_len;
    } t_job;

    // Bit count of a magnitude (JPEG category).
    function automatic logic [3:0] category(input logic [11:0] m);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (m[i]) begin
                c = 4'(i + 1);
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/jbe_queue.sv
`default_nettype none
module jbe_queue
    import jbe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/jbe_front.sv
`default_nettype none
module jbe_front
    import jbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [1:0]  i_component,
    input  wire logic [5:0]  i_position,
    input  wire logic [11:0] i_coefficient,
    input  wire logic [1:0]  i_table_select,
    input  wire logic [7:0]  i_symbol,
    input  wire logic [15:0] i_code_bits,
    input  wire logic [4:0]  i_code_length,
    output logic             o_push,
    output t_job             o_job,
    input  wire logic        i_full
);

    t_code r_dc_mem [DC_DEPTH];
    t_code r_ac_mem [AC_DEPTH];

    logic [11:0] r_pred [3];
    logic [5:0]  r_zero_run;

    // Second stage: table data arrives here from the registered reads.
    logic        r_bv;
    logic        r_isdc;
    logic        r_flush;
    logic [1:0]  r_nzrl;
    logic [11:0] r_mag;
    logic [3:0]  r_mag_len;
    t_code       r_dc_q;
    t_code       r_zrl_q;
    t_code       r_sym_q;

    logic                 acc;
    logic                 tab;
    logic [11:0]          pred;
    logic signed [12:0]   diff;
    logic signed [12:0]   dsat;
    logic [12:0]          dabs;
    logic signed [12:0]   cext;
    logic [12:0]          cabs;
    logic [3:0]           dcat;
    logic [3:0]           ccat;
    logic                 is_coef;
    logic                 is_dc;
    logic                 is_zero;
    logic                 is_eob;
    logic                 push_job;
    logic [7:0]           ac_sym;
    logic [DC_ADDR_W-1:0] dc_rd_addr;
    logic [DC_ADDR_W-1:0] dc_wr_addr;
    logic [AC_ADDR_W-1:0] zrl_addr;
    logic [AC_ADDR_W-1:0] sym_addr;
    logic [AC_ADDR_W-1:0] ac_wr_addr;
    t_code                wr_entry;
    logic                 dc_wr;
    logic                 ac_wr;

    assign o_ready = !r_bv || !i_full;
    assign acc     = i_valid && o_ready;
    assign tab     = (i_component != 2'd0);

    always_comb begin
        case (i_component)
            2'd1:    pred = r_pred[1];
            2'd2:    pred = r_pred[2];
            default: pred = r_pred[0];
        endcase
        diff = 13'(signed'(i_coefficient)) - 13'(signed'(pred));
        if (int'(diff) > DC_LIM) begin
            dsat = 13'(DC_LIM);
        end else if (int'(diff) < -DC_LIM) begin
            dsat = 13'(-DC_LIM);
        end else begin
            dsat = diff;
        end
        dabs = dsat[12] ? 13'(-dsat) : 13'(dsat);
        cext = 13'(signed'(i_coefficient));
        cabs = cext[12] ? 13'(-cext) : 13'(cext);
        dcat = category(dabs[11:0]);
        ccat = category(cabs[11:0]);
    end

    assign is_coef  = (i_mode == MODE_COEF) && (i_component != 2'd3);
    assign is_dc    = is_coef && (i_position == 6'd0);
    assign is_zero  = is_coef && !is_dc && (i_coefficient == 12'd0);
    assign is_eob   = is_zero && (i_position == 6'd63);
    assign push_job = (is_coef && !(is_zero && !is_eob)) || (i_mode == MODE_FLUSH);

    assign ac_sym     = is_eob ? SYM_EOB : {r_zero_run[3:0], ccat};
    assign dc_rd_addr = tab ? DC_ADDR_W'(DC_SYMBOLS) + DC_ADDR_W'(dcat) : DC_ADDR_W'(dcat);
    assign zrl_addr   = {tab, SYM_ZRL};
    assign sym_addr   = {tab, ac_sym};

    always_comb begin
        wr_entry.code = i_code_bits;
        wr_entry.len  = (i_code_length > 5'd16) ? 5'd16 : i_code_length;
    end
    assign dc_wr_addr = i_table_select[0] ? DC_ADDR_W'(DC_SYMBOLS) + DC_ADDR_W'(i_symbol)
                                          : DC_ADDR_W'(i_symbol);
    assign ac_wr_addr = {i_table_select[0], i_symbol};
    assign dc_wr = acc && (i_mode == MODE_LOAD) && !i_table_select[1]
                   && (int'(i_symbol) < DC_SYMBOLS);
    assign ac_wr = acc && (i_mode == MODE_LOAD) && i_table_select[1];

    always_ff @(posedge i_clk) begin
        if (dc_wr) begin
            r_dc_mem[dc_wr_addr] <= wr_entry;
        end
        if (ac_wr) begin
            r_ac_mem[ac_wr_addr] <= wr_entry;
        end
        if (acc) begin
            r_dc_q    <= r_dc_mem[dc_rd_addr];
            r_zrl_q   <= r_ac_mem[zrl_addr];
            r_sym_q   <= r_ac_mem[sym_addr];
            r_isdc    <= is_dc;
            r_flush   <= (i_mode == MODE_FLUSH);
            r_nzrl    <= (is_dc || is_eob) ? 2'd0 : r_zero_run[5:4];
            r_mag     <= is_dc ? (dsat[12] ? 12'(dsat - 13'sd1) : 12'(dsat))
                               : (cext[12] ? 12'(cext - 13'sd1) : 12'(cext));
            r_mag_len <= is_dc ? dcat : (is_eob ? 4'd0 : ccat);
        end
        if (!i_rst_n) begin
            r_bv       <= 1'b0;
            r_zero_run <= '0;
            r_pred[0]  <= '0;
            r_pred[1]  <= '0;
            r_pred[2]  <= '0;
        end else begin
            if (acc) begin
                r_bv <= push_job;
            end else if (!i_full) begin
                r_bv <= 1'b0;
            end
            if (acc && is_dc) begin
                r_zero_run <= '0;
                case (i_component)
                    2'd1:    r_pred[1] <= i_coefficient;
                    2'd2:    r_pred[2] <= i_coefficient;
                    default: r_pred[0] <= i_coefficient;
                endcase
            end else if (acc && is_zero) begin
                r_zero_run <= is_eob ? 6'd0 : r_zero_run + 6'd1;
            end else if (acc && is_coef) begin
                r_zero_run <= '0;
            end
        end
    end

    assign o_push = r_bv && !i_full;

    always_comb begin
        o_job.flush   = r_flush;
        o_job.nzrl    = r_nzrl;
        o_job.zrl     = r_zrl_q;
        o_job.sym     = r_isdc ? r_dc_q : r_sym_q;
        o_job.mag     = r_mag;
        o_job.mag_len = r_mag_len;
    end

endmodule
`default_nettype wire

### hw/rtl/jbe_back.sv
`default_nettype none
module jbe_back
    import jbe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_job       i_job,
    output logic            o_pop,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    logic [23:0] r_buf;
    logic [4:0]  r_cnt;
    logic [2:0]  r_idx;
    logic        r_done;
    logic        r_stuff;
    logic        r_stuff_last;
    logic [4:0]  r_nbytes;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;

    logic        can_out;
    logic        emit;
    logic [7:0]  top;
    logic        tail;
    logic        keep;
    logic        seg_zrl;
    logic        seg_code;
    t_code       seg;
    logic [16:0] mask;
    logic [23:0] ins;
    logic [4:0]  sh;
    logic [1:0]  zrl_left;
    logic [6:0]  rem_bits;

    assign can_out = !r_ov || i_tready;
    assign emit    = can_out && (r_stuff || (r_cnt >= 5'd8));
    assign top     = r_buf[23:16];
    assign keep    = (r_nbytes < 5'(MAX_OUT));

    assign seg_zrl  = ({1'b0, r_idx} < {2'b0, i_job.nzrl});
    assign seg_code = (r_idx == {1'b0, i_job.nzrl});

    // While a job is still being inserted, the bits it has yet to add decide whether
    // the byte going out now is the last one it produces.
    always_comb begin
        zrl_left = seg_zrl ? 2'(i_job.nzrl - r_idx[1:0]) : 2'd0;
        if (r_done) begin
            rem_bits = '0;
        end else begin
            rem_bits = 7'(zrl_left) * 7'(i_job.zrl.len)
                       + ((seg_zrl || seg_code) ? 7'(i_job.sym.len) : 7'd0)
                       + 7'(i_job.mag_len);
        end
    end
    assign tail = ((7'(r_cnt) + rem_bits) < 7'd16);

    always_comb begin
        if (seg_zrl) begin
            seg = i_job.zrl;
        end else if (seg_code) begin
            seg = i_job.sym;
        end else begin
            seg.code = {4'd0, i_job.mag};
            seg.len  = {1'b0, i_job.mag_len};
        end
        mask = (17'd1 << seg.len) - 17'd1;
        ins  = {8'd0, seg.code & mask[15:0]};
        sh   = 5'(5'd24 - r_cnt - seg.len);
    end

    // Jobs enter the bit buffer only once every whole byte of the one before is out.
    assign o_pop = i_valid && !r_stuff && (r_cnt < 5'd8)
                   && (i_job.flush || (!seg_zrl && !seg_code));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_done       <= 1'b0;
            r_stuff      <= 1'b0;
            r_stuff_last <= 1'b0;
            r_nbytes     <= '0;
            r_ov         <= 1'b0;
            r_ob         <= '0;
            r_ol         <= 1'b0;
        end else begin
            if (i_tready && !emit) begin
                r_ov <= 1'b0;
            end
            if (r_stuff) begin
                if (can_out) begin
                    r_stuff  <= 1'b0;
                    r_ov     <= keep;
                    r_ob     <= BYTE_STUFF;
                    r_ol     <= r_stuff_last || (r_nbytes == 5'(MAX_OUT - 1));
                    r_nbytes <= keep ? r_nbytes + 5'd1 : r_nbytes;
                end
            end else if (r_cnt >= 5'd8) begin
                if (can_out) begin
                    r_buf        <= {r_buf[15:0], 8'd0};
                    r_cnt        <= r_cnt - 5'd8;
                    r_ov         <= keep;
                    r_ob         <= top;
                    r_ol         <= (tail && top != BYTE_FF)
                                    || (r_nbytes == 5'(MAX_OUT - 1));
                    r_nbytes     <= keep ? r_nbytes + 5'd1 : r_nbytes;
                    r_stuff      <= (top == BYTE_FF);
                    r_stuff_last <= tail;
                end
            end else if (i_valid) begin
                if (i_job.flush) begin
                    if (r_cnt != 5'd0) begin
                        r_cnt    <= 5'd8;
                        r_done   <= 1'b1;
                        r_nbytes <= '0;
                    end
                end else begin
                    r_buf  <= r_buf | (ins << sh);
                    r_cnt  <= r_cnt + seg.len;
                    r_idx  <= o_pop ? 3'd0 : r_idx + 3'd1;
                    r_done <= o_pop;
                    if (r_idx == 3'd0) begin
                        r_nbytes <= '0;
                    end
                end
            end
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_ob;
    assign o_tlast  = r_ol;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 5'd23)
        else $error("bit buffer overfilled");
    a_nbytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbytes <= 5'(MAX_OUT))
        else $error("per-item byte count ran past the limit");
    a_stuff_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stuff) |-> $past(r_cnt) >= 5'd8)
        else $error("stuff byte without a full byte taken out");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> !$past(r_stuff))
        else $error("job retired while a stuff byte was pending");
`endif

endmodule
`default_nettype wire

### hw/rtl/jpeg_block_entropy_encoder_unit.sv
`default_nettype none
// Baseline JPEG Huffman entropy coder. Each transfer on the input carries one quantized
// coefficient in zigzag order (tuser = 0), a flush request (tuser = 1) or one Huffman
// table entry to load (tuser = 2). The output is the coded byte stream, one byte per
// transfer with 0x00 stuffed after 0xFF; tlast marks the final byte an input caused.
// A coefficient is looked up in the code tables by registered reads in the front, which
// overlap with other items; the bit packer then inserts each code segment in turn (each
// ZRL, the symbol code, the magnitude bits) and sends out each whole byte before it
// takes the next segment, while a four-entry job queue lets the front keep taking items.
module jpeg_block_entropy_encoder_unit
    import jbe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // component[1:0], position[7:2], coefficient[19:8], table_select[21:20],
    // symbol[29:22], code_bits[45:30], code_length[50:46], zero fill above
    input  wire logic [55:0] i_s_tdata,
    // mode[1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // out_byte[7:0]
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    logic push;
    logic full;
    logic pop;
    logic qv;
    t_job job_in;
    t_job job_out;

    jbe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_mode         (i_s_tuser),
        .i_component    (i_s_tdata[1:0]),
        .i_position     (i_s_tdata[7:2]),
        .i_coefficient  (i_s_tdata[19:8]),
        .i_table_select (i_s_tdata[21:20]),
        .i_symbol       (i_s_tdata[29:22]),
        .i_code_bits    (i_s_tdata[45:30]),
        .i_code_length  (i_s_tdata[50:46]),
        .o_push         (push),
        .o_job          (job_in),
        .i_full         (full)
    );

    jbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qv),
        .o_job   (job_out)
    );

    jbe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qv),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
